// File: rtl/tld_pkg.sv
// Shared types and constants of the terminal line discipline.
// Used by tld_ctrl, tty_line_discipline, tld_checker and tb; depends on nothing.
package tld_pkg;

    // Character codes handled by the discipline.
    localparam logic [7:0] CH_BS  = 8'h7f;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_ESC = 8'h1b;

    // Configuration register indexes.
    localparam logic [1:0] REG_CRLF_OUT = 2'd0;
    localparam logic [1:0] REG_CRLF_IN  = 2'd1;
    localparam logic [1:0] REG_ECHO     = 2'd2;
    localparam logic [1:0] REG_LIMIT    = 2'd3;

    // Width of the line limit and of length compares; holds any length up to 64.
    localparam int CMP_W = 7;

    // Position of the last byte of the erase sequence.
    localparam logic [3:0] ERASE_LAST = 4'd8;

    // Configuration as seen by the sequencer, limit already clamped.
    typedef struct packed {
        logic             crlf_out;
        logic             crlf_in;
        logic             echo_enable;
        logic [CMP_W-1:0] limit;
    } cfg_t;

    // Erase sequence: ESC [ 1 D space ESC [ 1 D.
    function automatic logic [7:0] erase_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = CH_ESC;
            4'd1:    b = 8'h5b;
            4'd2:    b = 8'h31;
            4'd3:    b = 8'h44;
            4'd4:    b = 8'h20;
            4'd5:    b = CH_ESC;
            4'd6:    b = 8'h5b;
            4'd7:    b = 8'h31;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/tld_line_ram.sv
// Line store of the terminal line discipline: one write port, one registered read port.
// Depends on nothing but its parameters.
module tld_line_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tld_ctrl.sv
// Sequencer of the terminal line discipline: edits the line store, then runs the
// shared byte-output step for echo and line delivery. Depends on tld_pkg.
module tld_ctrl import tld_pkg::*; #(
    parameter int AW       = 5,
    parameter int LEN_W    = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    // Input item.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    // Result item.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast,
    // Line store port.
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE2,
        ST_ECHO,
        ST_DLV_RD,
        ST_DLV_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } term_t;

    // One step of the terminal output expansion for byte b at position idx.
    function automatic term_t term_step(input logic [7:0] b, input logic [3:0] idx,
                                        input logic crlf_out);
        term_t t;
        if (b == CH_BS) begin
            t.b    = erase_byte(idx);
            t.last = (idx == ERASE_LAST);
        end else if (b == CH_LF && crlf_out) begin
            t.b    = (idx == 4'd0) ? CH_CR : CH_LF;
            t.last = (idx != 4'd0);
        end else begin
            t.b    = b;
            t.last = 1'b1;
        end
        return t;
    endfunction

    state_t            state_reg, state_next;
    logic [7:0]        tb_reg, tb_next;
    logic [3:0]        tidx_reg, tidx_next;
    logic              dlv_reg, dlv_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              is_nl;
    logic              two;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  new_len;
    term_t             ts;

    // Decode of the key against the current line length.
    always_comb begin
        len_ext = CMP_W'(len_reg);
        is_nl   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
        two     = is_nl && cfg.crlf_in && ((len_ext + CMP_W'(1)) < cfg.limit);
        new_len = len_ext + (two ? CMP_W'(2) : CMP_W'(1));
        ts      = term_step(tb_reg, tidx_reg, cfg.crlf_out);
        out_free = !out_valid_reg || m_tready;
    end

    // Next-state logic of the sequencer and the output register.
    always_comb begin
        state_next     = state_reg;
        tb_next        = tb_reg;
        tidx_next      = tidx_reg;
        dlv_next       = dlv_reg;
        len_next       = len_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = len_reg[AW-1:0];
        ram_wdata      = s_tdata;

        unique case (state_reg)
            ST_IDLE: begin
                tidx_next   = 4'd0;
                rd_idx_next = '0;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        // Software byte goes straight to terminal output.
                        tb_next    = s_tdata;
                        dlv_next   = 1'b0;
                        state_next = ST_ECHO;
                    end else if (s_tdata == CH_BS) begin
                        // Backspace: ignored on an empty line.
                        if (len_reg != '0) begin
                            len_next = len_reg - LEN_W'(1);
                            tb_next  = CH_BS;
                            dlv_next = 1'b0;
                            if (cfg.echo_enable) begin
                                state_next = ST_ECHO;
                            end
                        end
                    end else begin
                        // Store the key; a line end may take a second write.
                        ram_we    = 1'b1;
                        ram_wdata = two ? CH_CR : (is_nl ? CH_LF : s_tdata);
                        len_next  = len_reg + LEN_W'(1);
                        tb_next   = two ? CH_LF : s_tdata;
                        dlv_next  = is_nl || (new_len >= cfg.limit);
                        if (two) begin
                            state_next = ST_STORE2;
                        end else if (cfg.echo_enable) begin
                            state_next = ST_ECHO;
                        end else if (is_nl || (new_len >= cfg.limit)) begin
                            state_next = ST_DLV_RD;
                        end
                    end
                end
            end
            ST_STORE2: begin
                ram_we    = 1'b1;
                ram_wdata = CH_LF;
                len_next  = len_reg + LEN_W'(1);
                if (cfg.echo_enable) begin
                    state_next = ST_ECHO;
                end else begin
                    state_next = ST_DLV_RD;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ts.b;
                    out_kind_next  = 1'b0;
                    out_last_next  = ts.last && !dlv_reg;
                    if (ts.last) begin
                        tidx_next  = 4'd0;
                        state_next = dlv_reg ? ST_DLV_RD : ST_IDLE;
                    end else begin
                        tidx_next = tidx_reg + 4'd1;
                    end
                end
            end
            ST_DLV_RD: begin
                // Read address is presented; data is registered in the store.
                state_next = ST_DLV_EMIT;
            end
            ST_DLV_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_kind_next  = 1'b1;
                    out_last_next  = (rd_idx_reg + LEN_W'(1)) == len_reg;
                    if ((rd_idx_reg + LEN_W'(1)) == len_reg) begin
                        len_next    = '0;
                        rd_idx_next = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + LEN_W'(1);
                        state_next  = ST_DLV_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            tidx_reg      <= 4'd0;
            dlv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            tidx_reg      <= tidx_next;
            dlv_reg       <= dlv_next;
            out_valid_reg <= out_valid_next;
        end
        tb_reg       <= tb_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign ram_raddr = rd_idx_reg[AW-1:0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_last_reg;

endmodule

// File: rtl/tty_line_discipline.sv
// Terminal line discipline: a key-edited line store with echo and an output path.
// Steps: an item is accepted, a CR LF line end takes a second store write, then each
// terminal byte (up to 9) is sent; each delivered line byte takes a store read, then
// an emit. One item at a time: no new item is taken before the last result of the
// previous one is in the output register.
// Reset (aresetn, synchronous, active low): empty line, registers CR LF out and in on,
// echo on, limit 32. The line store itself is not cleared.
module tty_line_discipline import tld_pkg::*; #(
    parameter int LINE_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input items.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] kind
    // Result items.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] out_kind
    output logic       m_tlast,
    // Configuration writes.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int AW    = $clog2(LINE_MAX);
    localparam int LEN_W = $clog2(LINE_MAX + 1);

    logic             crlf_out_reg;
    logic             crlf_in_reg;
    logic             echo_reg;
    logic [5:0]       limit_reg;
    logic [CMP_W-1:0] limit_clamped;
    cfg_t             cfg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crlf_out_reg <= 1'b1;
            crlf_in_reg  <= 1'b1;
            echo_reg     <= 1'b1;
            limit_reg    <= 6'd32;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CRLF_OUT: crlf_out_reg <= cfg_data[0];
                REG_CRLF_IN:  crlf_in_reg  <= cfg_data[0];
                REG_ECHO:     echo_reg     <= cfg_data[0];
                REG_LIMIT:    limit_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // A limit of zero acts as one; a limit above the store size acts as the store size.
    always_comb begin
        if (limit_reg == 6'd0) begin
            limit_clamped = CMP_W'(1);
        end else if (CMP_W'(limit_reg) > CMP_W'(LINE_MAX)) begin
            limit_clamped = CMP_W'(LINE_MAX);
        end else begin
            limit_clamped = CMP_W'(limit_reg);
        end
        cfg.crlf_out    = crlf_out_reg;
        cfg.crlf_in     = crlf_in_reg;
        cfg.echo_enable = echo_reg;
        cfg.limit       = limit_clamped;
    end

    tld_ctrl #(
        .AW       (AW),
        .LEN_W    (LEN_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tld_line_ram #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A software byte always produces output, so the block is busy afterwards.
    a_sw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("block ready right after accepting a software byte");

    // While a result that is not the last of its item is shown, no new item is taken.
    a_busy_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("block ready while an item still has results to send");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

// File: sim/tld_checker.sv
// Checker for tty_line_discipline: watches the input, result and configuration channels.
// Keeps its own copy of the line store and registers, predicts every result and compares.
// Depends on tld_pkg for the character codes and register indexes.
`timescale 1ns / 1ps

module tld_checker import tld_pkg::*; #(
    parameter int LINE_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam logic TO_TERM   = 1'b0;
    localparam logic TO_READER = 1'b1;

    // One byte the block is due to send out.
    typedef struct {
        logic       to_reader;
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    // Erase sequence sent for a backspace: ESC [ 1 D space ESC [ 1 D.
    localparam logic [7:0] ERASE_SEQ [9] = '{
        8'h1b, 8'h5b, 8'h31, 8'h44, 8'h20, 8'h1b, 8'h5b, 8'h31, 8'h44
    };

    // Shadow of the registers and the line store.
    logic        crlf_out_q;
    logic        crlf_in_q;
    logic        echo_q;
    logic [5:0]  limit_q;
    logic [7:0]  line_buf [LINE_MAX];
    int unsigned line_len;

    out_byte_t   due_q [$];
    out_byte_t   step_q [$];
    out_byte_t   head;

    function void add_out(logic to_reader, logic [7:0] b);
        out_byte_t r;
        r.to_reader = to_reader;
        r.data      = b;
        r.last      = 1'b0;
        step_q.push_back(r);
    endfunction

    // Terminal output path: backspace becomes the erase sequence, LF may become CR LF.
    function void add_term(logic [7:0] b);
        if (b == CH_BS) begin
            for (int i = 0; i < 9; i++)
                add_out(TO_TERM, ERASE_SEQ[i]);
            return;
        end
        if (b == CH_LF && crlf_out_q)
            add_out(TO_TERM, CH_CR);
        add_out(TO_TERM, b);
    endfunction

    function void store_byte(logic [7:0] b);
        if (line_len < LINE_MAX) begin
            line_buf[line_len] = b;
            line_len++;
        end
    endfunction

    // Works out every byte that one input item causes and queues it.
    function void predict_line_output(logic from_sw, logic [7:0] b);
        int unsigned lim;
        logic [7:0]  echo_b;
        logic        deliver;
        lim     = limit_q;
        echo_b  = b;
        deliver = 1'b0;
        if (lim < 1) lim = 1;
        if (lim > LINE_MAX) lim = LINE_MAX;
        step_q.delete();
        if (from_sw) begin
            add_term(b);
        end else if (b == CH_BS) begin
            // A backspace on an empty line leaves no trace at all.
            if (line_len != 0) begin
                line_len--;
                if (echo_q)
                    add_term(CH_BS);
            end
        end else begin
            if (b == CH_LF || b == CH_CR) begin
                if (crlf_in_q && line_len + 1 < lim) begin
                    store_byte(CH_CR);
                    echo_b = CH_LF;
                end
                store_byte(CH_LF);
                deliver = 1'b1;
            end else begin
                store_byte(b);
            end
            if (line_len >= lim)
                deliver = 1'b1;
            if (echo_q)
                add_term(echo_b);
            if (deliver) begin
                for (int i = 0; i < line_len; i++)
                    add_out(TO_READER, line_buf[i]);
                line_len = 0;
            end
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                due_q.push_back(step_q[i]);
        end
    endfunction

    // Compare results first, so a result arriving with nothing due is caught.
    always @(posedge aclk) begin
        if (!aresetn) begin
            crlf_out_q = 1'b1;
            crlf_in_q  = 1'b1;
            echo_q     = 1'b1;
            limit_q    = 6'd32;
            line_len   = 0;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    $error("unexpected result: out_kind %0d out_byte %02h out_last %0d",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    head = due_q.pop_front();
                    if (m_tuser !== head.to_reader) begin
                        $error("out_kind: expected %0d, got %0d", head.to_reader, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== head.data) begin
                        $error("out_byte: expected %02h, got %02h", head.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head.last) begin
                        $error("out_last: expected %0d, got %0d", head.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CRLF_OUT: crlf_out_q = cfg_data[0];
                    REG_CRLF_IN:  crlf_in_q  = cfg_data[0];
                    REG_ECHO:     echo_q     = cfg_data[0];
                    REG_LIMIT:    limit_q    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_line_output(s_tuser, s_tdata);
        end
        pending = due_q.size();
    end

endmodule

// File: sim/tb.sv
// Top of the tty_line_discipline testbench: clock, reset, stimulus and verdict.
// Drives bursty input items, a stalling receiver and register writes between phases;
// tld_checker predicts and compares. Depends on tld_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import tld_pkg::*;

    localparam logic KEY  = 1'b0;
    localparam logic SOFT = 1'b1;
    localparam int   SETTLE_CYCLES = 160;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [5:0] cfg_data  = 6'd0;
    int         fail_count;
    int         pending;

    int          burst_left = 0;
    int          phase_items;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_tick = 0;

    tty_line_discipline #(.LINE_MAX(32)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tld_checker #(.LINE_MAX(32)) u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: switches between always ready, coin flips, one in four and long stalls.
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    rx_stall_left = $urandom_range(1, 8);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Sends one item; between bursts the valid line drops for a random gap.
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every due result has come and the block has settled.
    task automatic drain();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic crlf_out, input logic crlf_in,
                              input logic echo, input logic [5:0] limit);
        drain();
        write_reg(REG_CRLF_OUT, {5'd0, crlf_out});
        write_reg(REG_CRLF_IN, {5'd0, crlf_in});
        write_reg(REG_ECHO, {5'd0, echo});
        write_reg(REG_LIMIT, limit);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic type_run(input int n);
        for (int i = 0; i < n; i++)
            send_item(KEY, 8'($urandom_range(8'h20, 8'h7e)));
    endtask

    function automatic logic [5:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd2;
            3: return 6'd32;
            4: return 6'd63;
            5: return 6'($urandom_range(33, 62));
            default: return 6'($urandom_range(3, 31));
        endcase
    endfunction

    // A key as a user types it: mostly printable, with edits and line ends.
    function automatic logic [7:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 72) return CH_BS;
        if (r < 78) return CH_CR;
        if (r < 84) return CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        #5_000_000;
        $display("tty_line_discipline regression: fail");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings first.
        set_config(1'b1, 1'b1, 1'b1, 6'd32);
        send_item(SOFT, 8'h00);
        send_item(SOFT, 8'hff);
        send_item(SOFT, CH_LF);
        send_item(SOFT, CH_BS);
        send_item(SOFT, CH_CR);
        send_item(KEY, CH_BS);
        send_item(KEY, 8'h61);
        send_item(KEY, 8'h00);
        send_item(KEY, 8'hff);
        send_item(KEY, CH_BS);
        send_item(KEY, CH_CR);
        send_item(KEY, CH_LF);

        // Limit of two: line end without room for CR LF, then delivery at the limit.
        set_config(1'b0, 1'b1, 1'b1, 6'd2);
        send_item(KEY, 8'h78);
        send_item(KEY, CH_LF);
        send_item(KEY, 8'h79);
        send_item(KEY, CH_CR);
        send_item(KEY, 8'h70);
        send_item(KEY, 8'h71);

        // Limit zero acts as one; echo off.
        set_config(1'b1, 1'b1, 1'b0, 6'd0);
        send_item(KEY, CH_CR);
        send_item(KEY, 8'h80);

        // Limit lowered below the held length: backspace holds, next key delivers.
        set_config(1'b1, 1'b0, 1'b1, 6'd32);
        type_run(5);
        set_config(1'b1, 1'b0, 1'b1, 6'd3);
        send_item(KEY, CH_BS);
        send_item(KEY, 8'h7a);

        // Limit above the store size acts as the store size.
        set_config(1'b0, 1'b0, 1'b1, 6'd63);
        type_run(33);

        // Random phases with fresh settings; the line carries over between them.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(1'b1, 1'b1, 1'b1, 6'd32);
                1: set_config(1'b0, 1'b0, 1'b0, 6'd1);
                default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), pick_limit());
            endcase
            phase_items = 0;
            while (phase_items < 36) begin
                if ($urandom_range(0, 11) == 0) begin
                    int run_len;
                    run_len = $urandom_range(20, 40);
                    type_run(run_len);
                    phase_items += run_len;
                end else if ($urandom_range(0, 99) < 15) begin
                    send_item(SOFT, ($urandom_range(0, 3) == 0) ?
                              (($urandom_range(0, 1) == 1) ? CH_LF : CH_BS) :
                              8'($urandom_range(0, 255)));
                    phase_items++;
                end else begin
                    logic [7:0] k;
                    k = pick_key();
                    send_item(KEY, k);
                    if (k != CH_BS)
                        phase_items++;
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tty_line_discipline regression: pass");
        end else begin
            $display("tty_line_discipline regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/tld_pkg.sv
rtl/tld_line_ram.sv
rtl/tld_ctrl.sv
rtl/tty_line_discipline.sv
sim/tld_checker.sv
sim/tb.sv
